/* rtl/mm3_pkg.sv */
// Shared types, constants and helper functions for the MurmurHash3 block.
// Used by mm3_ctrl, mm3_dp and the top level murmur3_32bit_hash.
package mm3_pkg;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] CN = 32'he6546b64;
  localparam logic [31:0] F1 = 32'h85ebca6b;
  localparam logic [31:0] F2 = 32'hc2b2ae35;

  localparam logic [2:0] FULL_WORD = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // take an input item
    logic mix;   // fold k into h
    logic fin1;  // length xor, first shift xor and first avalanche multiply
    logic fin2;  // second shift xor and second avalanche multiply
    logic fin3;  // last shift xor into the output register
  } mm3_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;      // the item in work ends its message
    logic out_free;  // the output register can take a result this cycle
  } mm3_sts_t;

  function automatic logic [31:0] rotl15(input logic [31:0] x);
    return {x[16:0], x[31:17]};
  endfunction

  function automatic logic [31:0] rotl13(input logic [31:0] x);
    return {x[18:0], x[31:19]};
  endfunction

  // Keeps the valid low-order bytes of a word.
  function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
    logic [31:0] m;
    case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

/* rtl/mm3_ctrl.sv */
// Controller state machine for the MurmurHash3 block.
// Depends on mm3_pkg for the command and status structs.
module mm3_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  mm3_pkg::mm3_sts_t sts,
  output mm3_pkg::mm3_cmd_t cmd
);
  import mm3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = sts.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = ST_FIN3;
      end
      ST_FIN3: begin
        // Hold here until the previous result has been taken.
        cmd.fin3 = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/mm3_dp.sv */
// Datapath for the MurmurHash3 block: seed, running hash, byte total,
// k mix, avalanche and output register. Depends on mm3_pkg.
module mm3_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mm3_pkg::mm3_cmd_t cmd,
  output mm3_pkg::mm3_sts_t sts,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  logic [31:0]       word_i,
  input  logic [2:0]        count_i,
  input  logic              last_i,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);
  import mm3_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] h_r;
  logic [31:0] total_r;
  logic [31:0] k_r;
  logic [31:0] f_r;
  logic [31:0] hash_r;
  logic [2:0]  cnt_r;
  logic        last_r;
  logic        open_r;
  logic        outv_r;

  logic [2:0]  cnt_clamp;
  logic [31:0] k2;
  logic [31:0] h1;
  logic [31:0] f0;
  logic [31:0] g0;

  assign cnt_clamp = (count_i > FULL_WORD) ? FULL_WORD : count_i;
  assign k2        = rotl15(k_r) * C2;
  assign h1        = h_r ^ k2;
  assign f0        = (h_r ^ total_r) ^ ((h_r ^ total_r) >> 16);
  assign g0        = f_r ^ (f_r >> 13);

  assign sts.last     = last_r;
  assign sts.out_free = !outv_r || out_tready;
  assign out_tvalid   = outv_r;
  assign out_tdata    = hash_r;

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      open_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        seed_r <= cfg_data;
      end
      if (cmd.load) begin
        open_r <= 1'b1;
      end else if (cmd.mix && last_r) begin
        open_r <= 1'b0;
      end
      if (cmd.fin3) begin
        outv_r <= 1'b1;
      end else if (out_tready) begin
        outv_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k_r    <= (word_i & byte_mask(cnt_clamp)) * C1;
      cnt_r  <= cnt_clamp;
      last_r <= last_i;
      // A new message starts from the seed with a cleared byte total.
      if (open_r) begin
        total_r <= total_r + {29'd0, cnt_clamp};
      end else begin
        h_r     <= seed_r;
        total_r <= {29'd0, cnt_clamp};
      end
    end
    if (cmd.mix) begin
      // A short word is a tail: no rotate and no multiply-add on h.
      if (cnt_r == FULL_WORD) begin
        h_r <= (rotl13(h1) << 2) + rotl13(h1) + CN;
      end else begin
        h_r <= h1;
      end
    end
    if (cmd.fin1) begin
      f_r <= f0 * F1;
    end
    if (cmd.fin2) begin
      f_r <= g0 * F2;
    end
    if (cmd.fin3) begin
      hash_r <= f_r ^ (f_r >> 16);
    end
  end

endmodule

/* rtl/murmur3_32bit_hash.sv */
// MurmurHash3 x86_32 over a stream of little-endian 32-bit words.
// Each word is accepted, then mixed; a final word then passes through the avalanche
// states FIN1, FIN2 and FIN3 before the next item is accepted, and FIN3 waits until
// the output register is free; FIN3 loads the hash into that register. Reset (rst_n
// low, synchronous) clears the seed to 0, closes any open message and empties the
// output register.
module murmur3_32bit_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,     // seed
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,     // [31:0] data_word, [34:32] byte_count, rest zero
  input  logic        in_tlast,     // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata     // [31:0] hash_value
);
  import mm3_pkg::*;

  mm3_cmd_t cmd;
  mm3_sts_t sts;

  assign cfg_ready = 1'b1;

  mm3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mm3_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .word_i     (in_tdata[31:0]),
    .count_i    (in_tdata[34:32]),
    .last_i     (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* test/murmur3_hash_checker.sv */
// Checker for the MurmurHash3 stream block: watches the seed, input and result channels,
// keeps its own model of the running hash and compares every hash that comes out.
// Stands alone; instantiated next to the block by murmur3_32bit_hash_test.
`timescale 1ns / 1ps

module murmur3_hash_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,     // seed
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,     // [31:0] data_word, [34:32] byte_count, rest zero
  input  logic        in_tlast,     // last_word
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,    // [31:0] hash_value
  output int          mismatches,
  output int          outstanding,
  output int          hashes_checked
);

  localparam logic [31:0] K_MUL1   = 32'hcc9e2d51;
  localparam logic [31:0] K_MUL2   = 32'h1b873593;
  localparam logic [31:0] H_ADD    = 32'he6546b64;
  localparam logic [31:0] AVAL_M1  = 32'h85ebca6b;
  localparam logic [31:0] AVAL_M2  = 32'hc2b2ae35;
  localparam logic [2:0]  FULL_BYTES = 3'd4;
  localparam int          REPORT_LIMIT = 10;

  logic [31:0] seed_shadow;
  logic [31:0] acc_hash;
  logic [31:0] msg_bytes;
  logic        msg_active;
  logic [31:0] hash_fifo[$];

  function automatic logic [31:0] scramble_k(input logic [31:0] k);
    logic [31:0] t;
    t = k * K_MUL1;
    t = {t[16:0], t[31:17]};
    return t * K_MUL2;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * AVAL_M1;
    t = t ^ (t >> 13);
    t = t * AVAL_M2;
    return t ^ (t >> 16);
  endfunction

  // Folds one accepted item into the running hash and queues a hash on a final item.
  function automatic void absorb_word(input logic [31:0] word, input logic [2:0] count,
                                      input logic fin);
    logic [2:0]  nbytes;
    logic [31:0] keep;
    if (!msg_active) begin
      acc_hash   = seed_shadow;
      msg_bytes  = '0;
      msg_active = 1'b1;
    end
    nbytes = (count > FULL_BYTES) ? FULL_BYTES : count;
    if (nbytes == FULL_BYTES) begin
      acc_hash = acc_hash ^ scramble_k(word);
      acc_hash = {acc_hash[18:0], acc_hash[31:19]};
      acc_hash = acc_hash * 32'd5 + H_ADD;
    end else if (nbytes != 3'd0) begin
      // A short word is a tail: only its valid low bytes count and h is not rotated.
      keep     = (32'h1 << (8 * nbytes)) - 32'h1;
      acc_hash = acc_hash ^ scramble_k(word & keep);
    end
    msg_bytes = msg_bytes + nbytes;
    if (fin) begin
      hash_fifo.push_back(avalanche(acc_hash ^ msg_bytes));
      msg_active = 1'b0;
    end
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want,
                              input logic [31:0] got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : watch
    logic [31:0] want;
    if (!rst_n) begin
      seed_shadow    = '0;
      acc_hash       = '0;
      msg_bytes      = '0;
      msg_active     = 1'b0;
      mismatches     = 0;
      hashes_checked = 0;
      hash_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        seed_shadow = cfg_data;
      if (in_tvalid && in_tready)
        absorb_word(in_tdata[31:0], in_tdata[34:32], in_tlast);
      if (out_tvalid && out_tready) begin
        if (hash_fifo.size() == 0) begin
          note_failure("hash with no final item waiting", '0, out_tdata);
        end else begin
          want = hash_fifo.pop_front();
          hashes_checked++;
          if (want !== out_tdata)
            note_failure("hash mismatch", want, out_tdata);
        end
      end
    end
    outstanding <= hash_fifo.size();
  end

endmodule

/* test/murmur3_32bit_hash_test.sv */
// Top of the MurmurHash3 stream testbench: clock, reset, message stimulus, receiver stalls
// and the verdict. Needs murmur3_32bit_hash and murmur3_hash_checker.
`timescale 1ns / 1ps

module murmur3_32bit_hash_test;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 10;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;     // [31:0] data_word, [34:32] byte_count, rest zero
  logic        in_tlast   = 1'b0;   // last_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;           // [31:0] hash_value

  int mismatches;
  int outstanding;
  int hashes_checked;

  int items_sent    = 0;
  int messages_sent = 0;
  int seeds_written = 0;
  int burst_left    = 0;
  int gap_max       = 0;
  int rx_mode       = 0;
  int hold_asks     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int rx_tick       = 0;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  murmur3_32bit_hash dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  murmur3_hash_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .hashes_checked (hashes_checked)
  );

  // Receiver: a long hold-off when asked, otherwise the stall pattern of the current mode.
  always @(posedge clk) begin
    rx_tick++;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((rx_tick % 7) >= 3);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: nothing transferred for %0d cycles", quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one item, with a random gap before each new burst, and waits for its acceptance.
  task automatic push_word(input logic [31:0] word, input logic [2:0] count, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, count, word};
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (fin)
      messages_sent++;
  endtask

  // Stops offering, waits for every outstanding hash, then lets the block settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    seeds_written++;
  endtask

  // A message of full words with a final word of one to four bytes; a noisy one
  // also gets odd byte counts (zero, short, above four) anywhere.
  task automatic send_message(input int nwords, input bit noisy);
    logic [31:0] word;
    logic [2:0]  count;
    bit          fin;
    for (int i = 0; i < nwords; i++) begin
      fin   = (i == nwords - 1);
      count = fin ? 3'($urandom_range(1, 4)) : 3'd4;
      if (noisy && $urandom_range(0, 3) == 0)
        count = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 15))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      push_word(word, count, fin);
    end
  endtask

  task automatic run_phase(input logic [31:0] seed, input int rxm, input int gmax,
                           input int nitems);
    int target;
    int len;
    drain_results();
    write_seed(seed);
    rx_mode = rxm;
    gap_max = gmax;
    target  = items_sent + nitems;
    while (items_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_message(len, $urandom_range(0, 6) == 0);
      if ($urandom_range(0, 49) == 0)
        drain_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items with the reset seed of zero.
    rx_mode = 1;
    gap_max = 2;
    push_word(32'hffff_ffff, 3'd0, 1'b1);     // empty message, ignored data
    push_word(32'hffff_ffff, 3'd4, 1'b1);
    push_word(32'h0000_0000, 3'd4, 1'b1);
    push_word(32'h1234_5678, 3'd4, 1'b0);
    push_word(32'hdead_beef, 3'd4, 1'b0);
    push_word(32'hcafe_f00d, 3'd3, 1'b1);
    push_word(32'ha5a5_a5a5, 3'd1, 1'b1);     // upper bits must be ignored
    push_word(32'h8000_0000, 3'd2, 1'b1);
    push_word(32'h0000_ffff, 3'd5, 1'b1);     // counts above four act as four
    push_word(32'hffff_ffff, 3'd6, 1'b0);
    push_word(32'h0123_4567, 3'd7, 1'b1);
    push_word(32'h00ff_eedd, 3'd2, 1'b0);     // short word in mid-message
    push_word(32'h7654_3210, 3'd4, 1'b1);
    push_word(32'hffff_ffff, 3'd0, 1'b0);     // zero bytes in mid-message
    push_word(32'h1111_1111, 3'd4, 1'b0);
    push_word(32'h2222_2222, 3'd0, 1'b1);

    // A seed written while a message is open only applies to the next message.
    push_word(32'hdead_beef, 3'd4, 1'b0);
    drain_results();
    write_seed(32'h9747_b28c);
    push_word(32'hbeef_dead, 3'd3, 1'b1);
    push_word(32'h0000_0000, 3'd0, 1'b1);

    run_phase(32'hffff_ffff, 1, 4, 400);
    run_phase($urandom, 0, 0, 400);

    // Hold the receiver off while short messages keep coming, so that the block backs up.
    drain_results();
    write_seed(32'h8000_0001);
    rx_mode = 1;
    gap_max = 0;
    hold_asks++;
    for (int i = 0; i < 60; i++)
      send_message(1, 1'b0);

    run_phase($urandom, 2, 8, 300);
    run_phase($urandom, 3, 2, 400);
    run_phase(32'h0000_0000, 1, 3, 200);

    drain_results();
    $display("Covered %0d items in %0d messages under %0d seed settings; %0d hashes checked.",
             items_sent, messages_sent, seeds_written + 1, hashes_checked);
    $display("Included empty, short, oversized and mid-message seed cases and a long stall.");
    if (mismatches == 0 && outstanding == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
